[rtl/core/narp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package narp_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_MAX_NOTES   = 16;
  localparam int DEF_PITCH_WIDTH = 16;

  // Fixed field widths.
  localparam int MODE_W = 3;
  localparam int RAND_W = 16;
  localparam int PAT_W  = 2;

  // Input event codes.
  localparam logic [MODE_W-1:0] MODE_NOTE_ON    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE_OFF   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALL_OFF    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STEP_BEGIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STEP_END   = 3'd4;

  // Step order codes.
  localparam logic [PAT_W-1:0] PAT_UP     = 2'd0;
  localparam logic [PAT_W-1:0] PAT_DOWN   = 2'd1;
  localparam logic [PAT_W-1:0] PAT_RANDOM = 2'd2;
  localparam logic [PAT_W-1:0] PAT_HOLD   = 2'd3;

  // Output event codes.
  localparam logic ACT_ON  = 1'b0;
  localparam logic ACT_OFF = 1'b1;

  // Datapath micro-operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_IDX,
    OP_INC_READ,
    OP_INC,
    OP_SET_J_COUNT,
    OP_READ_JM1,
    OP_WRITE_J_DEC,
    OP_INSERT,
    OP_SET_J_IDX,
    OP_READ_JP1,
    OP_WRITE_J_INC,
    OP_REMOVE,
    OP_STOP,
    OP_CLR_COUNT,
    OP_EMIT_TABLE,
    OP_MUL,
    OP_MOD_SUB,
    OP_STEP_POS,
    OP_READ_POS,
    OP_LOAD_CUR,
    OP_EMIT_ON,
    OP_EMIT_OFF
  } dp_op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              playing;
    logic              sounding;
    logic              has_notes;
    logic              full;
    logic              idx_end;
    logic              idx_last;
    logic              rd_lt;
    logic              rd_eq;
    logic              j_at_idx;
    logic              j_last;
    logic              cur_ge_n;
    logic              pat_hold;
    logic              out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/narp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module narp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/narp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module narp_dp #(
  parameter int MAX_NOTES   = 16,
  parameter int PITCH_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire narp_pkg::dp_op_t               op,
  output narp_pkg::dp_status_t                status,
  input  wire logic [narp_pkg::MODE_W-1:0]    in_mode,
  input  wire logic signed [PITCH_WIDTH-1:0]  in_pitch,
  input  wire logic [narp_pkg::RAND_W-1:0]    in_random_value,
  input  wire logic                           cfg_wr_en,
  input  wire logic [narp_pkg::PAT_W-1:0]     cfg_wr_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_action,
  output logic signed [PITCH_WIDTH-1:0]       out_note_pitch,
  output logic                                out_last
);

  import narp_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NOTES);
  localparam int CNT_W  = $clog2(MAX_NOTES + 1);
  localparam int PROD_W = RAND_W + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NOTES);

  // Captured input event.
  logic [MODE_W-1:0]             mode_r;
  logic signed [PITCH_WIDTH-1:0] pitch_r;
  logic [RAND_W-1:0]             rand_r;

  // Player state.
  logic [PAT_W-1:0]              pattern_r;
  logic [CNT_W-1:0]              count_r;
  logic [IDX_W-1:0]              pos_r;
  logic                          pos_valid_r;
  logic                          playing_r;
  logic                          sounding_r;
  logic signed [PITCH_WIDTH-1:0] cur_pitch_r;

  // Scan and shift pointers, step arithmetic.
  logic [CNT_W-1:0]              idx_r;
  logic [IDX_W-1:0]              j_r;
  logic [IDX_W-1:0]              cur_r;
  logic [PROD_W-1:0]             prod_r;

  // Output register.
  logic                          out_valid_r;
  logic                          out_action_r;
  logic signed [PITCH_WIDTH-1:0] out_pitch_r;
  logic                          out_last_r;

  // Table memory ports.
  logic                          ram_wr_en;
  logic [IDX_W-1:0]              ram_wr_addr;
  logic [PITCH_WIDTH-1:0]        ram_wr_data;
  logic                          ram_rd_en;
  logic [IDX_W-1:0]              ram_rd_addr;
  logic [PITCH_WIDTH-1:0]        ram_rd_data;

  logic [CNT_W-1:0]              idx_inc;
  logic [IDX_W-1:0]              last_pos;
  logic                          cur_wrap;
  logic [IDX_W-1:0]              pos_nxt;
  logic                          out_free;
  logic                          emit;

  assign idx_inc  = idx_r + CNT_W'(1);
  assign last_pos = IDX_W'(count_r - CNT_W'(1));
  assign cur_wrap = (CNT_W'(cur_r) + CNT_W'(1)) == count_r;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (op == OP_EMIT_TABLE) || (op == OP_EMIT_ON) || (op == OP_EMIT_OFF);

  narp_ram #(
    .WIDTH (PITCH_WIDTH),
    .DEPTH (MAX_NOTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Table address and data selection for the current operation.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = j_r;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r[IDX_W-1:0];
    case (op)
      OP_READ_IDX: begin
        ram_rd_en = 1'b1;
      end
      OP_INC_READ: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_inc[IDX_W-1:0];
      end
      OP_READ_JM1: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = j_r - IDX_W'(1);
      end
      OP_READ_JP1: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = j_r + IDX_W'(1);
      end
      OP_READ_POS: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos_r;
      end
      OP_WRITE_J_DEC, OP_WRITE_J_INC: begin
        ram_wr_en = 1'b1;
      end
      OP_INSERT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r[IDX_W-1:0];
        ram_wr_data = pitch_r;
      end
      default: begin
      end
    endcase
  end

  // Next position from the reduced current position and the step order.
  always_comb begin
    case (pattern_r)
      PAT_UP: begin
        pos_nxt = (pos_valid_r && !cur_wrap) ? cur_r + IDX_W'(1) : '0;
      end
      PAT_DOWN: begin
        pos_nxt = (pos_valid_r && cur_r != '0) ? cur_r - IDX_W'(1) : last_pos;
      end
      PAT_RANDOM: begin
        pos_nxt = prod_r[RAND_W +: IDX_W];
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // Control and player state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= PAT_UP;
      count_r     <= '0;
      pos_r       <= '0;
      pos_valid_r <= 1'b0;
      playing_r   <= 1'b0;
      sounding_r  <= 1'b0;
      cur_pitch_r <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pattern_r <= cfg_wr_data;
      end
      // The output register empties on a transfer and refills on an emit.
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          idx_r <= '0;
        end
        OP_INC_READ, OP_INC: begin
          idx_r <= idx_inc;
        end
        OP_INSERT: begin
          count_r   <= count_r + CNT_W'(1);
          playing_r <= 1'b1;
        end
        OP_REMOVE: begin
          count_r <= count_r - CNT_W'(1);
          if (count_r == CNT_W'(1) && playing_r) begin
            playing_r   <= 1'b0;
            pos_r       <= '0;
            pos_valid_r <= 1'b0;
          end
        end
        OP_STOP: begin
          playing_r   <= 1'b0;
          pos_r       <= '0;
          pos_valid_r <= 1'b0;
        end
        OP_CLR_COUNT: begin
          count_r <= '0;
        end
        OP_EMIT_TABLE: begin
          idx_r <= idx_inc;
        end
        OP_STEP_POS: begin
          pos_r       <= pos_nxt;
          pos_valid_r <= 1'b1;
        end
        OP_LOAD_CUR: begin
          cur_pitch_r <= ram_rd_data;
        end
        OP_EMIT_ON: begin
          sounding_r <= 1'b1;
        end
        OP_EMIT_OFF: begin
          sounding_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        mode_r  <= in_mode;
        pitch_r <= in_pitch;
        rand_r  <= in_random_value;
      end
      OP_SET_J_COUNT: begin
        j_r <= count_r[IDX_W-1:0];
      end
      OP_SET_J_IDX: begin
        j_r <= idx_r[IDX_W-1:0];
      end
      OP_WRITE_J_DEC: begin
        j_r <= j_r - IDX_W'(1);
      end
      OP_WRITE_J_INC: begin
        j_r <= j_r + IDX_W'(1);
      end
      OP_MUL: begin
        prod_r <= PROD_W'(rand_r) * PROD_W'(count_r);
        cur_r  <= pos_r;
      end
      OP_MOD_SUB: begin
        cur_r <= IDX_W'(CNT_W'(cur_r) - count_r);
      end
      OP_EMIT_TABLE: begin
        out_action_r <= ACT_OFF;
        out_pitch_r  <= ram_rd_data;
        out_last_r   <= idx_inc == count_r;
      end
      OP_EMIT_ON: begin
        out_action_r <= ACT_ON;
        out_pitch_r  <= cur_pitch_r;
        out_last_r   <= 1'b1;
      end
      OP_EMIT_OFF: begin
        out_action_r <= ACT_OFF;
        out_pitch_r  <= cur_pitch_r;
        out_last_r   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    status.mode      = mode_r;
    status.playing   = playing_r;
    status.sounding  = sounding_r;
    status.has_notes = count_r != '0;
    status.full      = count_r >= MAX_CNT;
    status.idx_end   = idx_r >= count_r;
    status.idx_last  = idx_inc == count_r;
    status.rd_lt     = $signed(ram_rd_data) < pitch_r;
    status.rd_eq     = $signed(ram_rd_data) == pitch_r;
    status.j_at_idx  = CNT_W'(j_r) == idx_r;
    status.j_last    = (CNT_W'(j_r) + CNT_W'(1)) == count_r;
    status.cur_ge_n  = CNT_W'(cur_r) >= count_r;
    status.pat_hold  = pattern_r == PAT_HOLD;
    status.out_free  = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_note_pitch = out_pitch_r;
  assign out_last       = out_last_r;

  // The held count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("held count exceeds table size");

  // Play runs only while the table holds pitches.
  a_play_needs_notes: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> count_r != '0)
    else $error("playing with an empty table");

  // A valid position exists only during play.
  a_pos_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    pos_valid_r |-> playing_r)
    else $error("position valid while stopped");

  // An emit never overwrites a result that is still stalled.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT_TABLE || op == OP_EMIT_ON || op == OP_EMIT_OFF)
      |-> !(out_valid_r && out_stall))
    else $error("emit into a stalled output register");

endmodule

`default_nettype wire

[rtl/core/narp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module narp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire narp_pkg::dp_status_t status,
  output narp_pkg::dp_op_t          op
);

  import narp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_ON_RD,
    S_ON_CMP,
    S_ON_INS,
    S_ON_SH_RD,
    S_ON_SH_WR,
    S_OFF_RD,
    S_OFF_CMP,
    S_OFF_SH_RD,
    S_OFF_SH_WR,
    S_ALL_RD,
    S_ALL_EMIT,
    S_STEP_MOD,
    S_STEP_RD,
    S_STEP_WT,
    S_EMIT_ON,
    S_EMIT_OFF
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Items are taken only between events.
  assign in_stall = state_r != S_IDLE;

  // Sequencing of the table scan, shift and emit steps.
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (status.mode)
          MODE_NOTE_ON: begin
            state_nxt = S_ON_RD;
          end
          MODE_NOTE_OFF: begin
            state_nxt = S_OFF_RD;
          end
          MODE_ALL_OFF: begin
            op        = OP_STOP;
            state_nxt = S_ALL_RD;
          end
          MODE_STEP_BEGIN: begin
            if (status.playing && status.has_notes) begin
              if (status.pat_hold) begin
                state_nxt = S_EMIT_ON;
              end else begin
                op        = OP_MUL;
                state_nxt = S_STEP_MOD;
              end
            end else begin
              state_nxt = S_IDLE;
            end
          end
          MODE_STEP_END: begin
            state_nxt = status.sounding ? S_EMIT_OFF : S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      // Note-on: find the first entry not below the pitch.
      S_ON_RD: begin
        if (status.idx_end) begin
          state_nxt = S_ON_INS;
        end else begin
          op        = OP_READ_IDX;
          state_nxt = S_ON_CMP;
        end
      end
      S_ON_CMP: begin
        if (status.rd_eq) begin
          state_nxt = S_IDLE;
        end else if (status.rd_lt) begin
          if (status.idx_last) begin
            op        = OP_INC;
            state_nxt = S_ON_INS;
          end else begin
            op = OP_INC_READ;
          end
        end else begin
          state_nxt = S_ON_INS;
        end
      end
      S_ON_INS: begin
        if (status.full) begin
          state_nxt = S_IDLE;
        end else begin
          op        = OP_SET_J_COUNT;
          state_nxt = S_ON_SH_RD;
        end
      end
      // Open a gap by moving entries up from the top down.
      S_ON_SH_RD: begin
        if (status.j_at_idx) begin
          op        = OP_INSERT;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_READ_JM1;
          state_nxt = S_ON_SH_WR;
        end
      end
      S_ON_SH_WR: begin
        op        = OP_WRITE_J_DEC;
        state_nxt = S_ON_SH_RD;
      end
      // Note-off: find the matching entry.
      S_OFF_RD: begin
        if (status.idx_end) begin
          state_nxt = S_IDLE;
        end else begin
          op        = OP_READ_IDX;
          state_nxt = S_OFF_CMP;
        end
      end
      S_OFF_CMP: begin
        if (status.rd_eq) begin
          op        = OP_SET_J_IDX;
          state_nxt = S_OFF_SH_RD;
        end else if (status.idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          op = OP_INC_READ;
        end
      end
      // Close the gap by moving entries down.
      S_OFF_SH_RD: begin
        if (status.j_last) begin
          op        = OP_REMOVE;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_READ_JP1;
          state_nxt = S_OFF_SH_WR;
        end
      end
      S_OFF_SH_WR: begin
        op        = OP_WRITE_J_INC;
        state_nxt = S_OFF_SH_RD;
      end
      // All-off: release every held pitch in order, then clear.
      S_ALL_RD: begin
        if (status.idx_end) begin
          op        = OP_CLR_COUNT;
          state_nxt = S_IDLE;
        end else begin
          op        = OP_READ_IDX;
          state_nxt = S_ALL_EMIT;
        end
      end
      S_ALL_EMIT: begin
        if (status.out_free) begin
          op        = OP_EMIT_TABLE;
          state_nxt = S_ALL_RD;
        end
      end
      // Step-begin: reduce the position below the count, then move.
      S_STEP_MOD: begin
        if (status.cur_ge_n) begin
          op = OP_MOD_SUB;
        end else begin
          op        = OP_STEP_POS;
          state_nxt = S_STEP_RD;
        end
      end
      S_STEP_RD: begin
        op        = OP_READ_POS;
        state_nxt = S_STEP_WT;
      end
      S_STEP_WT: begin
        op        = OP_LOAD_CUR;
        state_nxt = S_EMIT_ON;
      end
      S_EMIT_ON: begin
        if (status.out_free) begin
          op        = OP_EMIT_ON;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_OFF: begin
        if (status.out_free) begin
          op        = OP_EMIT_OFF;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Every accepted item is decoded in the following cycle.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DISP)
    else $error("accepted item not dispatched");

endmodule

`default_nettype wire

[rtl/core/note_arpeggiator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Arpeggiator over a sorted, duplicate-free table of held pitches kept in a
// single-port-read RAM. One event is processed at a time; in_stall is low only
// between events. The table is walked one RAM access at a time: note-on scans
// for the first entry not below the pitch, then moves the entries above it up
// and inserts; note-off scans for its pitch and, if found, moves the entries
// above it down; all-off reads and releases each held pitch in order; outside
// hold order, step-begin reduces the stored position below the count by
// subtraction, then moves it and reads the pitch; step-end releases the sounding
// pitch. An output stall holds the events that emit. Results leave through one
// output register, so a finished result can wait on out_stall while the block
// takes the next event. The user must write the step order register through
// cfg_wr_en and cfg_wr_data only while no event is in progress; the block
// itself does not enforce it.
module note_arpeggiator #(
  parameter int MAX_NOTES   = narp_pkg::DEF_MAX_NOTES,
  parameter int PITCH_WIDTH = narp_pkg::DEF_PITCH_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [narp_pkg::MODE_W-1:0]   in_mode,
  input  wire logic signed [PITCH_WIDTH-1:0] in_pitch,
  input  wire logic [narp_pkg::RAND_W-1:0]   in_random_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_action,
  output logic signed [PITCH_WIDTH-1:0]      out_note_pitch,
  output logic                               out_last,
  input  wire logic                          cfg_wr_en,
  input  wire logic [narp_pkg::PAT_W-1:0]    cfg_wr_data
);

  import narp_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // Sequencer.
  narp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  // Table, player state and output register.
  narp_dp #(
    .MAX_NOTES   (MAX_NOTES),
    .PITCH_WIDTH (PITCH_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .status          (status),
    .in_mode         (in_mode),
    .in_pitch        (in_pitch),
    .in_random_value (in_random_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_note_pitch  (out_note_pitch),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

[tb/note_arpeggiator_tb.sv]
`timescale 1ns / 1ps

module note_arpeggiator_tb;
  import narp_pkg::*;

  localparam int MAX_N = DEF_MAX_NOTES;
  localparam int PW = DEF_PITCH_WIDTH;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_EVENTS = 56;

  typedef logic signed [PW-1:0] pitch_t;

  typedef struct {
    logic   action;
    pitch_t pitch;
    logic   last;
  } note_event_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [MODE_W-1:0]  in_mode = MODE_NOTE_ON;
  pitch_t             in_pitch = '0;
  logic [RAND_W-1:0]  in_random_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_action;
  pitch_t             out_note_pitch;
  logic               out_last;
  logic               cfg_wr_en = 1'b0;
  logic [PAT_W-1:0]   cfg_wr_data = PAT_UP;

  // Shadow of the arpeggiator state.
  pitch_t           held_pitch [MAX_N];
  int               held_n = 0;
  int               step_pos = 0;
  bit               step_pos_ok = 1'b0;
  bit               playing = 1'b0;
  bit               sounding = 1'b0;
  pitch_t           cur_pitch = '0;
  logic [PAT_W-1:0] step_order = PAT_UP;

  note_event_t pending_notes[$];

  int  mismatches = 0;
  int  events_sent = 0;
  int  notes_checked = 0;
  int  full_drops = 0;
  int  random_steps = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_gaps = 1'b1;
  int  out_hold_left = 0;

  note_arpeggiator #(
    .MAX_NOTES  (MAX_N),
    .PITCH_WIDTH(PW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_pitch       (in_pitch),
    .in_random_value(in_random_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_note_pitch (out_note_pitch),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  function automatic void expect_note(logic act, pitch_t p, logic lst);
    note_event_t e;
    e.action = act;
    e.pitch = p;
    e.last = lst;
    pending_notes.push_back(e);
  endfunction

  // Updates the shadow state for one accepted event and queues the note
  // events that the block should emit for it.
  function automatic void predict_note_events(logic [MODE_W-1:0] m, pitch_t p,
                                              logic [RAND_W-1:0] rv);
    int i;
    int cur;
    case (m)
      MODE_NOTE_ON: begin
        i = 0;
        while (i < held_n && held_pitch[i] < p) i++;
        if (i < held_n && held_pitch[i] == p) begin
          // Already held: nothing changes.
        end else if (held_n >= MAX_N) begin
          full_drops++;
        end else begin
          for (int j = held_n; j > i; j--) held_pitch[j] = held_pitch[j-1];
          held_pitch[i] = p;
          held_n++;
          playing = 1'b1;
        end
      end
      MODE_NOTE_OFF: begin
        i = 0;
        while (i < held_n && held_pitch[i] != p) i++;
        if (i < held_n) begin
          for (int j = i; j < held_n - 1; j++) held_pitch[j] = held_pitch[j+1];
          held_n--;
          if (held_n == 0 && playing) begin
            playing = 1'b0;
            step_pos = 0;
            step_pos_ok = 1'b0;
          end
        end
      end
      MODE_ALL_OFF: begin
        playing = 1'b0;
        step_pos = 0;
        step_pos_ok = 1'b0;
        for (int j = 0; j < held_n; j++) begin
          expect_note(ACT_OFF, held_pitch[j], j == held_n - 1);
        end
        held_n = 0;
      end
      MODE_STEP_BEGIN: begin
        if (playing && held_n > 0) begin
          // The stored position may be stale after a removal, so it is
          // wrapped into the table before it moves.
          cur = step_pos % held_n;
          case (step_order)
            PAT_UP:     step_pos = step_pos_ok ? (cur + 1) % held_n : 0;
            PAT_DOWN:   step_pos = step_pos_ok ? (cur + held_n - 1) % held_n : held_n - 1;
            PAT_RANDOM: begin
              step_pos = (int'(rv) * held_n) >> 16;
              random_steps++;
            end
            default: ;
          endcase
          if (step_order != PAT_HOLD) begin
            step_pos_ok = 1'b1;
            cur_pitch = held_pitch[step_pos];
          end
          sounding = 1'b1;
          expect_note(ACT_ON, cur_pitch, 1'b1);
        end
      end
      MODE_STEP_END: begin
        if (sounding) begin
          sounding = 1'b0;
          expect_note(ACT_OFF, cur_pitch, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one event, optionally after an idle burst, and waits for its transfer.
  task automatic send_event(logic [MODE_W-1:0] m, pitch_t p, logic [RAND_W-1:0] rv);
    if (tx_gaps && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_pitch <= p;
    in_random_value <= rv;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_note_events(m, p, rv);
    if (m <= MODE_STEP_END) events_sent++;
  endtask

  // Writes the step order once the block has drained and gone quiet.
  task automatic set_step_order(logic [PAT_W-1:0] pat);
    in_valid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pat;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_order = pat;
  endtask

  function automatic pitch_t pick_pitch();
    case ($urandom_range(0, 3))
      0, 1: return pitch_t'((int'($urandom_range(0, 23)) - 12) * 256);
      2: return pitch_t'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return pitch_t'(1 << (PW - 1));
          1: return pitch_t'((1 << (PW - 1)) - 1);
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Events with nothing to play, nothing sounding, nothing held, and
  // undefined mode codes.
  task automatic test_idle_events();
    set_step_order(PAT_UP);
    send_event(MODE_STEP_BEGIN, '0, '0);
    send_event(MODE_STEP_END, '0, '0);
    send_event(MODE_ALL_OFF, '0, '0);
    send_event(MODE_NOTE_OFF, pitch_t'(1234), '0);
    for (int m = MODE_STEP_END + 1; m < (1 << MODE_W); m++) begin
      send_event(m[MODE_W-1:0], '1, '1);
    end
  endtask

  // Extreme pitches in up order, a duplicate, a removal under the position,
  // and a release after play has stopped.
  task automatic test_up_steps();
    send_event(MODE_NOTE_ON, pitch_t'((1 << (PW - 1)) - 1), '0);
    send_event(MODE_NOTE_ON, pitch_t'(1 << (PW - 1)), '0);
    send_event(MODE_NOTE_ON, pitch_t'(1 << (PW - 1)), '0);
    send_event(MODE_STEP_BEGIN, '0, '0);
    send_event(MODE_STEP_END, '0, '0);
    send_event(MODE_STEP_BEGIN, '0, '1);
    send_event(MODE_NOTE_OFF, pitch_t'(1 << (PW - 1)), '0);
    send_event(MODE_STEP_BEGIN, '0, '0);
    send_event(MODE_NOTE_OFF, pitch_t'((1 << (PW - 1)) - 1), '0);
    send_event(MODE_STEP_BEGIN, '0, '0);
    send_event(MODE_STEP_END, '0, '0);
  endtask

  // Hold order repeats the sounding pitch; all-off releases a run of notes.
  task automatic test_hold_and_all_off();
    set_step_order(PAT_HOLD);
    send_event(MODE_NOTE_ON, '1, '0);
    send_event(MODE_NOTE_ON, '0, '0);
    send_event(MODE_STEP_BEGIN, '0, '0);
    send_event(MODE_ALL_OFF, '0, '0);
    send_event(MODE_STEP_END, '0, '0);
  endtask

  // Mostly musical phrases with random content, with some noise mixed in.
  task automatic test_random_phases();
    logic [PAT_W-1:0] orders [8] = '{PAT_UP, PAT_DOWN, PAT_RANDOM, PAT_HOLD,
                                     PAT_RANDOM, PAT_DOWN, PAT_UP, PAT_RANDOM};
    int on_pct;
    int counted;
    int r;
    logic [MODE_W-1:0] m;
    pitch_t p;
    logic [RAND_W-1:0] rv;
    for (int ph = 0; ph < 8; ph++) begin
      set_step_order(orders[ph]);
      tx_gaps = (ph % 3 != 1) && (ph != 7);
      rx_gaps = (ph % 3 != 2) && (ph != 7);
      on_pct = (ph % 2 == 0) ? 45 : 22;
      counted = 0;
      while (counted < PHASE_EVENTS) begin
        r = $urandom_range(0, on_pct + 54);
        p = pick_pitch();
        rv = RAND_W'($urandom);
        if ($urandom_range(0, 9) == 0) rv = $urandom_range(0, 1) ? '1 : '0;
        if (r < on_pct) begin
          m = MODE_NOTE_ON;
        end else if (r < on_pct + 12) begin
          m = MODE_NOTE_OFF;
          if (held_n > 0 && $urandom_range(0, 3) != 0) begin
            p = held_pitch[$urandom_range(0, held_n - 1)];
          end
        end else if (r < on_pct + 37) begin
          m = MODE_STEP_BEGIN;
        end else if (r < on_pct + 49) begin
          m = MODE_STEP_END;
        end else if (r < on_pct + 52) begin
          m = MODE_ALL_OFF;
        end else begin
          m = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
        end
        send_event(m, p, rv);
        if (m <= MODE_STEP_END) counted++;
      end
    end
  endtask

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (out_hold_left > 0) begin
      out_hold_left <= out_hold_left - 1;
    end else if (rx_gaps && $urandom_range(0, 99) < 20) begin
      out_stall <= 1'b1;
      out_hold_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transfer against the oldest expected note event.
  always @(posedge clk) begin : check_notes
    note_event_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      notes_checked++;
      if (pending_notes.size() == 0) begin
        report_mismatch($sformatf("unexpected note event action=%0b pitch=%0d last=%0b",
                                  out_action, out_note_pitch, out_last));
      end else begin
        want = pending_notes.pop_front();
        if (out_action !== want.action)
          report_mismatch($sformatf("action %0b, expected %0b", out_action, want.action));
        if (out_note_pitch !== want.pitch)
          report_mismatch($sformatf("pitch %0d, expected %0d", out_note_pitch, want.pitch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_events();
    test_up_steps();
    test_hold_and_all_off();
    test_random_phases();
    in_valid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d events across up, down, random and hold orders; checked %0d notes.",
             events_sent, notes_checked);
    $display("Full-table drops: %0d, random-order steps: %0d, mismatches: %0d.",
             full_drops, random_steps, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
